FILE: rtl/gwm_pkg.sv
// gwm_pkg: types and constants shared by the glob wildcard matcher
// used by glob_wildcard_matcher_core, gwm_cell and gwm_closure; depends on nothing
package gwm_pkg;

	localparam int MaxPattern = 64;
	localparam int NumPos     = MaxPattern + 1;
	localparam int LenW       = $clog2(MaxPattern + 1);

	localparam logic [7:0] AnyOne = 8'h3F;
	localparam logic [7:0] AnyRun = 8'h2A;

	typedef enum logic [1:0] {
		OpPattern = 2'd0,
		OpText    = 2'd1,
		OpEnd     = 2'd2
	} opcode_t;

	typedef struct packed {
		logic       clear;
		logic       step;
		logic [7:0] ch;
	} cell_ctrl_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} rsp_t;

endpackage

FILE: rtl/gwm_if.sv
// gwm_in_if / gwm_out_if: valid-ready channels of the glob wildcard matcher
// no dependencies
interface gwm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] char_value;
	logic       new_pattern;

	modport source (output valid, opcode, char_value, new_pattern, input ready);
	modport sink   (input valid, opcode, char_value, new_pattern, output ready);
endinterface

interface gwm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, matched, pattern_overflow, input ready);
	modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

FILE: rtl/glob_wildcard_matcher_core.sv
// glob_wildcard_matcher_core: top level of the glob matcher ('*' and '?')
// depends on gwm_pkg, gwm_if, gwm_cell, gwm_closure
//
//   port  | dir  | payload                              | results
//   cmd   | sink | opcode, char_value, new_pattern      | one per end-of-text transfer
//   rsp   | src  | matched, pattern_overflow            | -
//
// one command per cycle, every opcode, while cmd.ready is high; the report is
// registered in out_q, or in skid_q while out_q is held. the per-cycle path is
// the 65-bit star closure add followed by the byte compare in each position cell.
// reset: pattern length zero, only position zero active, no overflow; pattern
// bytes stay undefined until written.
// stalls: a two-entry result buffer; cmd.ready drops only when both are held.
module glob_wildcard_matcher_core (
	input  logic       clk,
	input  logic       arst_n,
	gwm_in_if.sink     cmd,
	gwm_out_if.source  rsp
);

	localparam int MaxPattern = gwm_pkg::MaxPattern;
	localparam int NumPos     = gwm_pkg::NumPos;
	localparam int LenW       = gwm_pkg::LenW;

	logic                  acc;
	logic                  pat_acc;
	logic                  end_acc;
	gwm_pkg::cell_ctrl_t   ctrl;
	logic [LenW-1:0]       len_q;
	logic                  ovf_q;
	logic                  last_q;
	logic [MaxPattern-1:0] wr_en;
	logic [MaxPattern-1:0] in_use;
	logic [MaxPattern-1:0] star_mask;
	logic [MaxPattern-1:0] cell_active;
	logic [NumPos-1:0]     match;
	logic [NumPos-1:0]     raw;
	logic [NumPos-1:0]     closed;
	gwm_pkg::rsp_t         res;
	gwm_pkg::rsp_t         out_q;
	gwm_pkg::rsp_t         skid_q;
	logic                  out_valid_q;
	logic                  skid_valid_q;
	logic                  pop;

	assign acc     = cmd.valid && cmd.ready;
	assign pat_acc = acc && (cmd.opcode == gwm_pkg::OpPattern);
	assign end_acc = acc && (cmd.opcode == gwm_pkg::OpEnd);

	assign ctrl.clear = (pat_acc && cmd.new_pattern) || end_acc;
	assign ctrl.step  = acc && (cmd.opcode == gwm_pkg::OpText);
	assign ctrl.ch    = cmd.char_value;

	assign match[0] = 1'b0;

	genvar p;
	generate
		for (p = 0; p < MaxPattern; p++) begin : g_pos
			assign in_use[p] = LenW'(p) < len_q;
			assign wr_en[p]  = pat_acc && (cmd.new_pattern ? (p == 0) : (len_q == LenW'(p)));

			gwm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.first     (p == 0),
				.wr_en     (wr_en[p]),
				.in_use    (in_use[p]),
				.closed    (closed[p]),
				.match_in  (match[p]),
				.star      (star_mask[p]),
				.active    (cell_active[p]),
				.match_out (match[p+1])
			);
		end
	endgenerate

	assign raw = {last_q, cell_active};

	gwm_closure u_closure (
		.raw       (raw),
		.star_mask (star_mask),
		.closed    (closed)
	);

	// final position, past the last pattern cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (ctrl.clear) begin
			last_q <= 1'b0;
		end else if (ctrl.step) begin
			last_q <= match[MaxPattern];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (pat_acc) begin
			if (cmd.new_pattern) begin
				len_q <= LenW'(1);
				ovf_q <= 1'b0;
			end else if (len_q < LenW'(MaxPattern)) begin
				len_q <= len_q + LenW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign res.matched          = closed[len_q] && !ovf_q;
	assign res.pattern_overflow = ovf_q;

	// result register plus skid entry
	assign pop       = out_valid_q && rsp.ready;
	assign cmd.ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= end_acc;
			end else begin
				out_valid_q  <= end_acc;
			end
		end else if (end_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (end_acc) begin
					skid_q <= res;
				end
			end else if (end_acc) begin
				out_q <= res;
			end
		end else if (end_acc) begin
			skid_q <= res;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.matched          = out_q.matched;
	assign rsp.pattern_overflow = out_q.pattern_overflow;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in front");

	a_ovf_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LenW'(MaxPattern)))
		else $error("overflow flagged below full pattern length");

	a_end_clears_positions: assert property (@(posedge clk) disable iff (!arst_n)
		end_acc |=> (raw == NumPos'(1)))
		else $error("position set not cleared after end of text");

	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LenW'(MaxPattern))
		else $error("pattern length beyond store");

	a_end_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(end_acc && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
		else $error("report lost on empty result buffer");

endmodule

FILE: rtl/gwm_cell.sv
// gwm_cell: one pattern position, holding its pattern byte and active bit
// depends on gwm_pkg
module gwm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  gwm_pkg::cell_ctrl_t ctrl,
	input  logic                first,
	input  logic                wr_en,
	input  logic                in_use,
	input  logic                closed,
	input  logic                match_in,
	output logic                star,
	output logic                active,
	output logic                match_out
);

	logic [7:0] pat_q;
	logic       active_q;
	logic       active_d;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= ctrl.ch;
		end
	end

	assign star      = in_use && (pat_q == gwm_pkg::AnyRun);
	assign match_out = closed && in_use && (pat_q != gwm_pkg::AnyRun)
		&& ((pat_q == gwm_pkg::AnyOne) || (pat_q == ctrl.ch));

	always_comb begin
		priority if (ctrl.clear) begin
			active_d = first;
		end else if (ctrl.step) begin
			active_d = (closed && star) || match_in;
		end else begin
			active_d = active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= first;
		end else begin
			active_q <= active_d;
		end
	end

	assign active = active_q;

endmodule

FILE: rtl/gwm_closure.sv
// gwm_closure: spreads active positions across runs of star bytes
// carry-chain form: seeds on stars ripple through the run like a carry; depends on gwm_pkg
module gwm_closure (
	input  logic [gwm_pkg::NumPos-1:0]     raw,
	input  logic [gwm_pkg::MaxPattern-1:0] star_mask,
	output logic [gwm_pkg::NumPos-1:0]     closed
);

	logic [gwm_pkg::NumPos-1:0] mask;
	logic [gwm_pkg::NumPos-1:0] seeds;
	logic [gwm_pkg::NumPos-1:0] sum;

	assign mask   = {1'b0, star_mask};
	assign seeds  = raw & mask;
	assign sum    = seeds + mask;
	assign closed = raw | (sum ^ mask);

endmodule

FILE: verif/gwm_match_check.sv
`timescale 1ns / 100ps
// gwm_match_check: watches the cmd and rsp channels of the glob matcher, keeps its
// own pattern store and active position set, and checks each report in order
// depends on gwm_pkg and the gwm_in_if / gwm_out_if interfaces
module gwm_match_check
	import gwm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	gwm_in_if    cmd,
	gwm_out_if   rsp,
	output int   mismatches,
	output int   pending
);

	logic [7:0]        pat_mem [MaxPattern];
	int                pat_len;
	logic [NumPos-1:0] live;
	logic              overflowed;
	rsp_t              expected_reports [$];

	task automatic report_mismatch(input string what, input logic got, input logic want);
		$display("%0t ns mismatch: %s got %0b expected %0b", $realtime, what, got, want);
		mismatches++;
	endtask

	// a star at a live position may match nothing
	task automatic spread_stars();
		for (int p = 0; p < pat_len; p++) begin
			if (live[p] && pat_mem[p] == AnyRun)
				live[p + 1] = 1'b1;
		end
	endtask

	task automatic take_char(input logic [7:0] c);
		logic [NumPos-1:0] nxt;
		nxt = '0;
		spread_stars();
		for (int p = 0; p < pat_len; p++) begin
			if (live[p]) begin
				if (pat_mem[p] == AnyRun)
					nxt[p] = 1'b1;
				else if (pat_mem[p] == AnyOne || pat_mem[p] == c)
					nxt[p + 1] = 1'b1;
			end
		end
		live = nxt;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			pat_len = 0;
			live = NumPos'(1);
			overflowed = 1'b0;
			expected_reports.delete();
			mismatches = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.matched = rsp.matched;
				got.pattern_overflow = rsp.pattern_overflow;
				if (expected_reports.size() == 0) begin
					report_mismatch("report transfer with nothing pending", 1'b1, 1'b0);
				end else begin
					want = expected_reports.pop_front();
					if (got.matched !== want.matched)
						report_mismatch("matched", got.matched, want.matched);
					if (got.pattern_overflow !== want.pattern_overflow)
						report_mismatch("pattern_overflow", got.pattern_overflow,
							want.pattern_overflow);
				end
			end
			if (cmd.valid && cmd.ready) begin
				case (opcode_t'(cmd.opcode))
					OpPattern: begin
						if (cmd.new_pattern) begin
							pat_len = 0;
							overflowed = 1'b0;
							live = NumPos'(1);
						end
						if (pat_len < MaxPattern) begin
							pat_mem[pat_len] = cmd.char_value;
							pat_len++;
						end else begin
							overflowed = 1'b1;
						end
					end
					OpText: take_char(cmd.char_value);
					OpEnd: begin
						spread_stars();
						want.matched = live[pat_len] && !overflowed;
						want.pattern_overflow = overflowed;
						expected_reports = {expected_reports, want};
						live = NumPos'(1);
					end
					default: ;
				endcase
			end
		end
		pending = expected_reports.size();
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives pattern, text, end-of-text and unused opcodes into the matcher
// with random idle gaps on both channels; gwm_match_check does the checking
// depends on gwm_pkg, gwm_if, glob_wildcard_matcher_core and gwm_match_check
module tb_top;
	import gwm_pkg::*;

	localparam int         TextItems = 1350;
	localparam logic [1:0] OpUnused  = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   items_sent;
	bit   cmd_quiet;
	bit   rsp_quiet;
	logic [7:0] pat_q [$];
	logic [7:0] text_q [$];

	gwm_in_if  cmd ();
	gwm_out_if rsp ();

	glob_wildcard_matcher_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	gwm_match_check match_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap(input bit quiet);
		return quiet ? 0 : int'($urandom_range(18, 0));
	endfunction

	function automatic logic [7:0] pick_char(input bit for_pattern);
		int roll;
		roll = $urandom_range(99, 0);
		if (for_pattern && roll < 25)
			return AnyRun;
		if (for_pattern && roll < 40)
			return AnyOne;
		if (roll < 85)
			return 8'h61 + 8'($urandom_range(2, 0));
		return 8'($urandom_range(255, 0));
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send(input logic [1:0] op, input logic [7:0] c, input logic fresh);
		int gap;
		gap = draw_gap(cmd_quiet);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			cmd.opcode <= 2'($urandom);
			cmd.char_value <= 8'($urandom);
			cmd.new_pattern <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.opcode <= op;
		cmd.char_value <= c;
		cmd.new_pattern <= fresh;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
		if (op != OpUnused)
			items_sent++;
		if ($urandom_range(29, 0) == 0)
			cmd_quiet = !cmd_quiet;
	endtask

	task automatic send_pattern();
		foreach (pat_q[i])
			send(OpPattern, pat_q[i], i == 0);
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send(OpText, text_q[i], 1'($urandom));
		send(OpEnd, 8'($urandom), 1'($urandom));
	endtask

	// a text that the current pattern matches, then maybe broken a little
	task automatic text_from_pattern();
		int idx;
		text_q.delete();
		foreach (pat_q[i]) begin
			if (pat_q[i] == AnyRun)
				repeat ($urandom_range(3, 0)) text_q = {text_q, pick_char(1'b0)};
			else if (pat_q[i] == AnyOne)
				text_q = {text_q, 8'($urandom_range(255, 0))};
			else
				text_q = {text_q, pat_q[i]};
		end
		if ($urandom_range(4, 0) == 0) begin
			if (text_q.size() == 0) begin
				text_q = {text_q, pick_char(1'b0)};
			end else begin
				idx = $urandom_range(text_q.size() - 1, 0);
				case ($urandom_range(2, 0))
					0: text_q[idx] = pick_char(1'b0);
					1: text_q.delete(idx);
					default: text_q = {text_q, pick_char(1'b0)};
				endcase
			end
		end
	endtask

	initial begin : stimulus
		int len;
		int roll;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.opcode = OpPattern;
		cmd.char_value = 8'h00;
		cmd.new_pattern = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty pattern after reset: matches only the empty text
		send(OpEnd, 8'h00, 1'b0);
		send(OpText, 8'hFF, 1'b1);
		send(OpEnd, 8'hFF, 1'b1);
		send(OpUnused, 8'hFF, 1'b1);
		// lone star, with and without text
		send(OpPattern, AnyRun, 1'b1);
		send(OpText, 8'hFF, 1'b0);
		send(OpText, 8'h00, 1'b0);
		send(OpEnd, 8'h00, 1'b0);
		send(OpEnd, 8'h00, 1'b0);
		// lone question mark
		send(OpPattern, AnyOne, 1'b1);
		send(OpEnd, 8'h00, 1'b0);
		send(OpText, 8'h80, 1'b0);
		send(OpEnd, 8'h00, 1'b0);
		// zero byte literal
		send(OpPattern, 8'h00, 1'b1);
		send(OpText, 8'h00, 1'b0);
		send(OpEnd, 8'h00, 1'b0);
		// pattern grows while a text is in flight
		send(OpPattern, 8'h61, 1'b1);
		send(OpText, 8'h61, 1'b0);
		send(OpPattern, 8'h62, 1'b0);
		send(OpText, 8'h62, 1'b0);
		send(OpEnd, 8'h00, 1'b0);

		while (items_sent < TextItems) begin
			roll = $urandom_range(99, 0);
			if (roll < 80)
				len = $urandom_range(8, 1);
			else if (roll < 92)
				len = $urandom_range(MaxPattern - 1, 9);
			else if (roll < 96)
				len = MaxPattern;
			else
				len = $urandom_range(MaxPattern + 6, MaxPattern + 1);
			pat_q.delete();
			repeat (len) pat_q = {pat_q, pick_char(1'b1)};
			send_pattern();
			repeat ($urandom_range(4, 1)) begin
				roll = $urandom_range(99, 0);
				if (roll < 65) begin
					text_from_pattern();
				end else begin
					text_q.delete();
					repeat ($urandom_range(6, 0)) text_q = {text_q, pick_char(1'b0)};
				end
				roll = $urandom_range(99, 0);
				if (roll < 8) begin
					send(OpUnused, 8'($urandom), 1'($urandom));
				end else if (roll < 13) begin
					pat_q = {pat_q, pick_char(1'b1)};
					send(OpPattern, pat_q[pat_q.size() - 1], 1'b0);
				end
				send_text();
			end
		end
		cmd.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin : rsp_pace
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(rsp_quiet);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			@(negedge clk);
			if ($urandom_range(29, 0) == 0)
				rsp_quiet = !rsp_quiet;
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/gwm_pkg.sv
rtl/gwm_if.sv
rtl/gwm_cell.sv
rtl/gwm_closure.sv
rtl/glob_wildcard_matcher_core.sv
verif/gwm_match_check.sv
verif/tb_top.sv
